[rtl/grf_pkg.sv]
// Package for the gated residual fusion block: sizes, field widths, codes
// and the sigmoid lookup table. No dependencies.
package grf_pkg;

  // Vector sizes.
  localparam int QUERY_SIZE  = 32;
  localparam int OUTPUT_SIZE = 16;
  localparam int W_DEPTH     = QUERY_SIZE * OUTPUT_SIZE;
  localparam int W_AW        = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
  localparam int Q_AW        = (QUERY_SIZE > 1) ? $clog2(QUERY_SIZE) : 1;
  localparam int O_AW        = (OUTPUT_SIZE > 1) ? $clog2(OUTPUT_SIZE) : 1;

  // Field widths.
  localparam int DATA_W      = 16;
  localparam int IDX_W       = 12;
  localparam int OUT_IDX_W   = 6;
  localparam int CFG_IDX_W   = 8;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;

  // Datapath widths.
  localparam int OP_W     = 25;
  localparam int PROD_W   = 2 * OP_W;
  localparam int SUM_W    = 38;
  localparam int RAD_W    = SUM_W + 16;
  localparam int ROOT_W   = RAD_W / 2;
  localparam int REM_W    = ROOT_W + 2;
  localparam int DEN_W    = ROOT_W + 1;
  localparam int ITER_W   = $clog2(ROOT_W);
  localparam int DIV_STEPS = 16;
  localparam int ACC_W    = 40;
  localparam int FPROD_W  = 36;
  localparam int SIG_STEP = 23;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FAST  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELIB = 8'd1;
  localparam logic [DATA_W-1:0] FAST_RESET  = 16'd52429;
  localparam logic [DATA_W-1:0] DELIB_RESET = 16'd32768;

  typedef enum logic [1:0] {
    CMD_WEIGHT = 2'd0,
    CMD_BIAS   = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_PAIR   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_FAST     = 2'd0,
    MODE_DELIB    = 2'd1,
    MODE_CONFLICT = 2'd2
  } mode_e;

  // Tag that follows a product through the shared multiplier.
  typedef enum logic [2:0] {
    TAG_SG, TAG_SL, TAG_SE, TAG_MAC, TAG_SIG, TAG_FUSE
  } tag_e;

  typedef enum logic [3:0] {
    S_IDLE, S_NORM, S_NORM_WAIT, S_SQRT, S_DIV0, S_DIV, S_MODE, S_ELEM,
    S_MAC, S_MAC_WAIT, S_SIG, S_SIG_WAIT, S_FUSE, S_FUSE_WAIT, S_OUT
  } state_e;

  // Sigmoid in Q0.16 at steps of 0.5 over 0..8.
  function automatic logic [DATA_W-1:0] sig_lut(input logic [4:0] k);
    logic [DATA_W-1:0] v;
    unique case (k)
      5'd0:  v = 16'd32768;
      5'd1:  v = 16'd40793;
      5'd2:  v = 16'd47911;
      5'd3:  v = 16'd53580;
      5'd4:  v = 16'd57724;
      5'd5:  v = 16'd60565;
      5'd6:  v = 16'd62428;
      5'd7:  v = 16'd63615;
      5'd8:  v = 16'd64357;
      5'd9:  v = 16'd64816;
      5'd10: v = 16'd65097;
      5'd11: v = 16'd65269;
      5'd12: v = 16'd65374;
      5'd13: v = 16'd65438;
      5'd14: v = 16'd65476;
      5'd15: v = 16'd65500;
      default: v = 16'd65514;
    endcase
    return v;
  endfunction

endpackage

[rtl/gated_residual_fusion.sv]
// Gated residual fusion: stores, sequencer, shared multiplier, root and divide.
// Depends on grf_pkg.
//
// Load items (weights, biases, query elements, prediction pairs) go in one per cycle.
// A prediction pair with tlast starts a run during which no item is accepted: the norm
// products, three bit-serial square roots and the division where needed, then per output
// element either a direct result in fast mode or, otherwise, a multiply-accumulate over
// the query (one multiply-accumulate per cycle through the single shared multiplier),
// a sigmoid and a fusion product on the same multiplier.
// Results leave through an output register, so a stalled consumer only holds the
// sequencer at the next result.
module gated_residual_fusion (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // index[11:0], value_a[27:12], value_b[43:28], zero fill
  input  logic [grf_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  input  logic s_axis_tlast,
  // cmd[1:0]
  input  logic [1:0] s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // fused[15:0], gate[31:16], agreement[47:32], out_index[53:48], zero fill
  output logic [grf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic m_axis_tlast,
  // mode[1:0]
  output logic [1:0] m_axis_tuser,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic [grf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [grf_pkg::DATA_W-1:0] cfg_data_i
);
  import grf_pkg::*;

  state_e state_q, state_d;

  // Input decode.
  logic in_acc;
  cmd_e in_cmd;
  logic [IDX_W-1:0] in_index;
  logic signed [DATA_W-1:0] in_a, in_b;
  assign in_acc   = s_axis_tvalid & s_axis_tready;
  assign in_cmd   = cmd_e'(s_axis_tuser);
  assign in_index = s_axis_tdata[11:0];
  assign in_a     = s_axis_tdata[27:12];
  assign in_b     = s_axis_tdata[43:28];

  // Stores.
  logic signed [DATA_W-1:0] wmem [W_DEPTH];
  logic signed [DATA_W-1:0] qmem [QUERY_SIZE];
  logic signed [DATA_W-1:0] bmem [OUTPUT_SIZE];
  logic signed [DATA_W-1:0] gmem [OUTPUT_SIZE];
  logic signed [DATA_W-1:0] lmem [OUTPUT_SIZE];
  logic signed [DATA_W-1:0] w_rd_q, h_rd_q;

  // Sequencer counters and results.
  logic [O_AW-1:0] e_q;
  logic [Q_AW-1:0] j_q;
  logic [W_AW-1:0] waddr_q;
  tag_e sel_q, sq_sel_q;
  logic [ITER_W-1:0] it_q;
  logic [DATA_W-1:0] fast_q, delib_q;

  // Multiplier pipeline.
  logic iss_v;
  tag_e iss_tag;
  logic signed [OP_W-1:0] iss_a, iss_b;
  logic v1_q, v2_q;
  tag_e tag1_q, tag2_q;
  logic signed [OP_W-1:0] op_a_q, op_b_q, mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic pipe_busy;

  logic [SUM_W-1:0] sg_q, sl_q, se_q;
  logic [RAD_W-1:0] rad_q;
  logic [REM_W-1:0] rem_q, rem_nx;
  logic [ROOT_W-1:0] root_q, root_nx, ng_q, nl_q, ne_q;
  logic [REM_W+1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic [DEN_W-1:0] den, den_q, r_q;
  logic [DEN_W:0] r2;
  logic r_ge;
  logic [DIV_STEPS-1:0] q_q, q_nx;
  logic [DATA_W-1:0] agr_q;
  mode_e mode_q;

  logic signed [ACC_W-1:0] acc_q;
  logic acc_neg;
  logic [ACC_W-1:0] acc_mag;
  logic sig_sat;
  logic [3:0] seg;
  logic [SIG_STEP-1:0] frac;
  logic [DATA_W-1:0] seg_base, seg_diff, base_q, sig_frac_q, sig_val;
  logic neg_q, sat_q;
  logic [DATA_W-1:0] gate_q, gate_d;
  logic signed [FPROD_W-1:0] fuse_prod_q, fuse_rnd;
  logic signed [20:0] fuse_sum;
  logic signed [DATA_W-1:0] fused_q, fused_d;

  logic signed [DATA_W-1:0] g_cur, l_cur, bias_cur;
  logic signed [DATA_W:0] e_cur;

  logic out_valid_q, out_free, out_last_q;
  logic [DATA_W-1:0] out_fused_q, out_gate_q, out_agr_q;
  logic [OUT_IDX_W-1:0] out_idx_q;
  mode_e out_mode_q;

  assign g_cur    = gmem[e_q];
  assign l_cur    = lmem[e_q];
  assign bias_cur = bmem[e_q];
  assign e_cur    = (DATA_W+1)'(l_cur) - (DATA_W+1)'(g_cur);
  assign pipe_busy = v1_q | v2_q;
  assign out_free  = ~out_valid_q | m_axis_tready;
  assign cfg_ready_o = 1'b1;

  // Store writes and registered reads.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      unique case (in_cmd)
        CMD_WEIGHT: if ({1'b0, in_index} < (IDX_W+1)'(W_DEPTH)) wmem[in_index[W_AW-1:0]] <= in_a;
        CMD_BIAS:   if ({1'b0, in_index} < (IDX_W+1)'(OUTPUT_SIZE)) bmem[in_index[O_AW-1:0]] <= in_a;
        CMD_QUERY:  if ({1'b0, in_index} < (IDX_W+1)'(QUERY_SIZE)) qmem[in_index[Q_AW-1:0]] <= in_a;
        CMD_PAIR: begin
          if ({1'b0, in_index} < (IDX_W+1)'(OUTPUT_SIZE)) begin
            gmem[in_index[O_AW-1:0]] <= in_a;
            lmem[in_index[O_AW-1:0]] <= in_b;
          end
        end
      endcase
    end
    w_rd_q <= wmem[waddr_q];
    h_rd_q <= qmem[j_q];
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_q  <= FAST_RESET;
      delib_q <= DELIB_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == REG_FAST) fast_q <= cfg_data_i;
      if (cfg_index_i == REG_DELIB) delib_q <= cfg_data_i;
    end
  end

  // Sigmoid segment lookup from the accumulated gate input.
  assign acc_neg  = acc_q[ACC_W-1];
  assign acc_mag  = acc_neg ? ACC_W'(-acc_q) : ACC_W'(acc_q);
  assign sig_sat  = |acc_mag[ACC_W-1:SIG_STEP+4];
  assign seg      = acc_mag[SIG_STEP+3:SIG_STEP];
  assign frac     = acc_mag[SIG_STEP-1:0];
  assign seg_base = sig_lut({1'b0, seg});
  assign seg_diff = sig_lut({1'b0, seg} + 5'd1) - seg_base;
  assign sig_val  = base_q + (sat_q ? '0 : sig_frac_q);
  assign gate_d   = neg_q ? DATA_W'(17'h10000 - {1'b0, sig_val}) : sig_val;

  // Rounded fused value with saturation.
  assign fuse_rnd = (fuse_prod_q + FPROD_W'(32768)) >>> 16;
  assign fuse_sum = 21'(g_cur) + 21'(fuse_rnd);
  always_comb begin
    if (fuse_sum > 21'sd32767) fused_d = 16'sh7FFF;
    else if (fuse_sum < -21'sd32768) fused_d = 16'sh8000;
    else fused_d = fuse_sum[DATA_W-1:0];
  end

  // One step of the bit-serial square root.
  assign rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
  assign trial  = {root_q, 2'b01};
  always_comb begin
    if (rem_sh >= (REM_W+2)'(trial)) begin
      rem_nx  = REM_W'(rem_sh - (REM_W+2)'(trial));
      root_nx = {root_q[ROOT_W-2:0], 1'b1};
    end else begin
      rem_nx  = REM_W'(rem_sh);
      root_nx = {root_q[ROOT_W-2:0], 1'b0};
    end
  end

  // One step of the restoring divider.
  assign den  = DEN_W'(ng_q) + DEN_W'(nl_q);
  assign r2   = {r_q, 1'b0};
  assign r_ge = r2 >= {1'b0, den_q};
  assign q_nx = {q_q[DIV_STEPS-2:0], r_ge};

  // Shared multiplier.
  assign mul_a  = (tag1_q == TAG_MAC) ? OP_W'(w_rd_q) : op_a_q;
  assign mul_b  = (tag1_q == TAG_MAC) ? OP_W'(h_rd_q) : op_b_q;
  assign prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_acc && in_cmd == CMD_PAIR && s_axis_tlast) state_d = S_NORM;
      S_NORM: if (sel_q == TAG_SE && e_q == O_AW'(OUTPUT_SIZE - 1)) state_d = S_NORM_WAIT;
      S_NORM_WAIT: if (!pipe_busy) state_d = S_SQRT;
      S_SQRT: if (it_q == ITER_W'(ROOT_W - 1) && sq_sel_q == TAG_SE) state_d = S_DIV0;
      S_DIV0: state_d = (den == '0 || DEN_W'(ne_q) >= den) ? S_MODE : S_DIV;
      S_DIV: if (it_q == ITER_W'(DIV_STEPS - 1)) state_d = S_MODE;
      S_MODE: state_d = S_ELEM;
      S_ELEM: state_d = (mode_q == MODE_FAST) ? S_OUT : S_MAC;
      S_MAC: if (j_q == Q_AW'(QUERY_SIZE - 1)) state_d = S_MAC_WAIT;
      S_MAC_WAIT: if (!pipe_busy) state_d = S_SIG;
      S_SIG: state_d = S_SIG_WAIT;
      S_SIG_WAIT: if (!pipe_busy) state_d = S_FUSE;
      S_FUSE: state_d = S_FUSE_WAIT;
      S_FUSE_WAIT: if (!pipe_busy) state_d = S_OUT;
      S_OUT: begin
        if (out_free) state_d = (e_q == O_AW'(OUTPUT_SIZE - 1)) ? S_IDLE : S_ELEM;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs: ready and multiplier issue.
  always_comb begin
    s_axis_tready = (state_q == S_IDLE);
    iss_v   = 1'b0;
    iss_tag = TAG_SG;
    iss_a   = '0;
    iss_b   = '0;
    unique case (state_q)
      S_NORM: begin
        iss_v   = 1'b1;
        iss_tag = sel_q;
        if (sel_q == TAG_SG) begin
          iss_a = OP_W'(g_cur);
          iss_b = OP_W'(g_cur);
        end else if (sel_q == TAG_SL) begin
          iss_a = OP_W'(l_cur);
          iss_b = OP_W'(l_cur);
        end else begin
          iss_a = OP_W'(e_cur);
          iss_b = OP_W'(e_cur);
        end
      end
      S_MAC: begin
        iss_v   = 1'b1;
        iss_tag = TAG_MAC;
      end
      S_SIG: begin
        iss_v   = ~sig_sat;
        iss_tag = TAG_SIG;
        iss_a   = OP_W'(seg_diff);
        iss_b   = OP_W'(frac);
      end
      S_FUSE: begin
        iss_v   = 1'b1;
        iss_tag = TAG_FUSE;
        iss_a   = OP_W'(gate_q);
        iss_b   = OP_W'(e_cur);
      end
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      v1_q    <= iss_v;
      v2_q    <= v1_q;
      if (state_q == S_OUT && out_free) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    tag1_q <= iss_tag;
    op_a_q <= iss_a;
    op_b_q <= iss_b;
    tag2_q <= tag1_q;
    prod_q <= prod_d;

    // Retire a product.
    if (v2_q) begin
      unique case (tag2_q)
        TAG_SG:   sg_q <= sg_q + SUM_W'(prod_q);
        TAG_SL:   sl_q <= sl_q + SUM_W'(prod_q);
        TAG_SE:   se_q <= se_q + SUM_W'(prod_q);
        TAG_MAC:  acc_q <= acc_q + ACC_W'(prod_q);
        TAG_SIG:  sig_frac_q <= prod_q[SIG_STEP+DATA_W-1:SIG_STEP];
        TAG_FUSE: fuse_prod_q <= FPROD_W'(prod_q);
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        e_q   <= '0;
        sel_q <= TAG_SG;
        sg_q  <= '0;
        sl_q  <= '0;
        se_q  <= '0;
      end
      S_NORM: begin
        if (sel_q == TAG_SE) begin
          sel_q <= TAG_SG;
          e_q   <= e_q + 1'b1;
        end else begin
          sel_q <= (sel_q == TAG_SG) ? TAG_SL : TAG_SE;
        end
      end
      S_NORM_WAIT: begin
        rad_q    <= {sg_q, 16'b0};
        rem_q    <= '0;
        root_q   <= '0;
        it_q     <= '0;
        sq_sel_q <= TAG_SG;
      end
      S_SQRT: begin
        if (it_q == ITER_W'(ROOT_W - 1)) begin
          it_q   <= '0;
          rem_q  <= '0;
          root_q <= '0;
          if (sq_sel_q == TAG_SG) begin
            ng_q     <= root_nx;
            rad_q    <= {sl_q, 16'b0};
            sq_sel_q <= TAG_SL;
          end else if (sq_sel_q == TAG_SL) begin
            nl_q     <= root_nx;
            rad_q    <= {se_q, 16'b0};
            sq_sel_q <= TAG_SE;
          end else begin
            ne_q <= root_nx;
          end
        end else begin
          rem_q  <= rem_nx;
          root_q <= root_nx;
          rad_q  <= rad_q << 2;
          it_q   <= it_q + 1'b1;
        end
      end
      S_DIV0: begin
        den_q <= den;
        r_q   <= DEN_W'(ne_q);
        q_q   <= '0;
        it_q  <= '0;
        if (den == '0) agr_q <= 16'hFFFF;
        else if (DEN_W'(ne_q) >= den) agr_q <= '0;
      end
      S_DIV: begin
        r_q  <= r_ge ? DEN_W'(r2 - {1'b0, den_q}) : DEN_W'(r2);
        q_q  <= q_nx;
        it_q <= it_q + 1'b1;
        if (it_q == ITER_W'(DIV_STEPS - 1)) begin
          agr_q <= (q_nx == '0) ? 16'hFFFF : DATA_W'(17'h10000 - {1'b0, q_nx});
        end
      end
      S_MODE: begin
        if (agr_q > fast_q) mode_q <= MODE_FAST;
        else if (agr_q > delib_q) mode_q <= MODE_DELIB;
        else mode_q <= MODE_CONFLICT;
        e_q     <= '0;
        waddr_q <= '0;
      end
      S_ELEM: begin
        j_q <= '0;
        if (mode_q == MODE_FAST) begin
          fused_q <= g_cur;
          gate_q  <= '0;
        end else begin
          acc_q <= {(ACC_W-12)'(bias_cur), 12'b0};
        end
      end
      S_MAC: begin
        j_q     <= j_q + 1'b1;
        waddr_q <= waddr_q + 1'b1;
      end
      S_SIG: begin
        neg_q  <= acc_neg;
        sat_q  <= sig_sat;
        base_q <= sig_sat ? sig_lut(5'd16) : seg_base;
      end
      S_SIG_WAIT: if (!pipe_busy) gate_q <= gate_d;
      S_FUSE_WAIT: if (!pipe_busy) fused_q <= fused_d;
      S_OUT: begin
        if (out_free) begin
          out_fused_q <= fused_q;
          out_gate_q  <= gate_q;
          out_agr_q   <= agr_q;
          out_mode_q  <= mode_q;
          out_idx_q   <= OUT_IDX_W'(e_q);
          out_last_q  <= (e_q == O_AW'(OUTPUT_SIZE - 1));
          e_q         <= e_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b0, out_idx_q, out_agr_q, out_gate_q, out_fused_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_mode_q;

  // The multiplier pipeline is empty whenever the block waits for items.
  a_idle_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !v2_q) else $error("product in flight while idle");

  // The sigmoid stage starts only after every gate product has been retired.
  a_sig_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SIG |-> !v1_q && !v2_q) else $error("sigmoid read before drain");

  // Fast mode results carry a zero gate.
  a_fast_gate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_mode_q == MODE_FAST |-> out_gate_q == '0)
    else $error("nonzero gate in fast mode");

  // The last result of a run carries the highest element index.
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_last_q |-> out_idx_q == OUT_IDX_W'(OUTPUT_SIZE - 1))
    else $error("last result with wrong index");

endmodule
